[hw/rtl/cau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int W  = 32;
    localparam int F  = 16;
    localparam int PW = 2 * W;
    localparam int SW = PW + 2;
    localparam int MW = SW - 1;
    localparam int QB = W + 1;
    localparam int XW = MW + F;
    localparam int RW = MW + 1;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [W-1:0] a_real;
        logic signed [W-1:0] a_imag;
        logic signed [W-1:0] b_real;
        logic signed [W-1:0] b_imag;
    } req_t;

    typedef struct packed {
        logic signed [W-1:0] res_real;
        logic signed [W-1:0] res_imag;
        logic [1:0]          status;
    } rsp_t;

    typedef struct packed {
        cmd_t          cmd;
        logic          neg_r;
        logic          neg_i;
        logic [MW-1:0] mag_r;
        logic [MW-1:0] mag_i;
        logic [MW-1:0] den;
    } front_t;

    typedef struct packed {
        cmd_t          cmd;
        logic          neg_r;
        logic          neg_i;
        logic [MW-1:0] mag_r;
        logic [MW-1:0] mag_i;
        logic          den_zero;
    } side_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] xb;
        logic [QB-1:0] quo;
        logic          ovf;
        logic [MW-1:0] den;
    } lane_t;

    typedef struct packed {
        logic         sat;
        logic [W-1:0] word;
    } enc_t;

    function automatic logic [MW-1:0] abs_mag(input logic signed [SW-1:0] v);
        logic [SW-1:0] u;
        u = v[SW-1] ? SW'(-v) : SW'(v);
        return u[MW-1:0];
    endfunction

    function automatic enc_t encode(input logic neg, input logic [MW-1:0] mag,
                                    input logic ovf);
        logic [MW-1:0] limit;
        logic [MW-1:0] m;
        enc_t          e;
        limit  = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
        e.sat  = ovf || (mag > limit);
        m      = e.sat ? limit : mag;
        e.word = neg ? (~m[W-1:0] + W'(1)) : m[W-1:0];
        return e;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cau_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module cau_div_cell
    import cau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire lane_t lane_in,
    output lane_t      lane_out
);

    lane_t         lane_reg;
    lane_t         lane_next;
    logic [RW-1:0] r2;
    logic [RW-1:0] d2;
    logic          ge;

    // one restoring quotient bit per cell
    always_comb
    begin
        r2             = {lane_in.rem[RW-2:0], lane_in.xb[QB-1]};
        d2             = {1'b0, lane_in.den};
        ge             = r2 >= d2;
        lane_next      = lane_in;
        lane_next.rem  = ge ? (r2 - d2) : r2;
        lane_next.xb   = {lane_in.xb[QB-2:0], 1'b0};
        lane_next.quo  = {lane_in.quo[QB-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

[hw/rtl/cau_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cau_front
    import cau_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_vld,
    input  wire req_t in_beat,
    output logic      out_vld,
    output front_t    out_data
);

    logic [2:0]            vld_reg;
    cmd_t                  cmd1_reg, cmd2_reg;
    logic signed [PW-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_dr_reg, p_di_reg;
    logic signed [W:0]     sum_r_reg, sum_i_reg;
    logic signed [W:0]     sum_r_next, sum_i_next;
    logic signed [SW-1:0]  val_r_reg, val_i_reg, val_r_next, val_i_next;
    logic [MW-1:0]         den2_reg, den2_next;
    front_t                f_reg, f_next;
    logic [MW-1:0]         mr, mi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_comb
    begin
        if (cmd_t'(in_beat.command) == CMD_SUB)
        begin
            sum_r_next = (W+1)'(in_beat.a_real) - (W+1)'(in_beat.b_real);
            sum_i_next = (W+1)'(in_beat.a_imag) - (W+1)'(in_beat.b_imag);
        end
        else
        begin
            sum_r_next = (W+1)'(in_beat.a_real) + (W+1)'(in_beat.b_real);
            sum_i_next = (W+1)'(in_beat.a_imag) + (W+1)'(in_beat.b_imag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg  <= cmd_t'(in_beat.command);
            p_rr_reg  <= in_beat.a_real * in_beat.b_real;
            p_ii_reg  <= in_beat.a_imag * in_beat.b_imag;
            p_ri_reg  <= in_beat.a_real * in_beat.b_imag;
            p_ir_reg  <= in_beat.a_imag * in_beat.b_real;
            p_dr_reg  <= in_beat.b_real * in_beat.b_real;
            p_di_reg  <= in_beat.b_imag * in_beat.b_imag;
            sum_r_reg <= sum_r_next;
            sum_i_reg <= sum_i_next;
        end
    end

    always_comb
    begin
        unique case (cmd1_reg)
            CMD_ADD, CMD_SUB:
            begin
                val_r_next = SW'(sum_r_reg);
                val_i_next = SW'(sum_i_reg);
            end
            CMD_MUL:
            begin
                val_r_next = SW'(p_rr_reg) - SW'(p_ii_reg);
                val_i_next = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            default:
            begin
                val_r_next = SW'(p_rr_reg) + SW'(p_ii_reg);
                val_i_next = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
        endcase
        den2_next = {1'b0, p_dr_reg} + {1'b0, p_di_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd2_reg  <= cmd1_reg;
            val_r_reg <= val_r_next;
            val_i_reg <= val_i_next;
            den2_reg  <= den2_next;
        end
    end

    always_comb
    begin
        mr             = abs_mag(val_r_reg);
        mi             = abs_mag(val_i_reg);
        f_next.cmd     = cmd2_reg;
        f_next.neg_r   = val_r_reg[SW-1];
        f_next.neg_i   = val_i_reg[SW-1];
        f_next.mag_r   = (cmd2_reg == CMD_MUL) ? (mr >> F) : mr;
        f_next.mag_i   = (cmd2_reg == CMD_MUL) ? (mi >> F) : mi;
        f_next.den     = den2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg <= f_next;
        end
    end

    assign out_vld  = vld_reg[2];
    assign out_data = f_reg;

endmodule

`default_nettype wire

[hw/rtl/complex_arithmetic_unit_core.sv]
// Complex arithmetic unit, signed Q16.16 operands and results.
// Request channel (req_valid/req_ready/req) carries one command and two
// complex operands per beat; response channel (rsp_valid/rsp_ready/rsp)
// returns one beat per request, in order, with the saturated result and a
// status code (ok, divide by zero, overflow).
// Throughput: one beat per cycle while rsp_ready does not stall the
// pipeline. A request reaches the response through 38 register stages:
// three front stages (products and sums, combined values, magnitudes),
// one divider entry stage, a chain of 33 divider cells that each resolve
// one quotient bit, and the response register. Every command takes the
// same path. When rsp_ready is low while a response is held, the whole
// pipeline freezes and req_ready drops; otherwise a held response and a
// new request move in the same cycle.
// Reset clears all valid bits; no response is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit_core
    import cau_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic           en;
    logic           f_vld;
    front_t         f_data;
    logic [QB:0]    vld_reg;
    side_t          side_reg [QB+1];
    side_t          side_next;
    lane_t          lr_entry, li_entry, lr_reg, li_reg;
    lane_t          lr_chain [QB+1];
    lane_t          li_chain [QB+1];
    logic [XW-1:0]  xr, xi;
    logic [RW-1:0]  r0r, r0i;
    logic           rsp_valid_reg;
    rsp_t           rsp_reg, rsp_next;
    side_t          sl;
    enc_t           er, ei;
    logic [MW-1:0]  mr, mi;
    logic           ovr, ovi;

    assign en        = !rsp_valid_reg || rsp_ready;
    assign req_ready = en;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (req_valid),
        .in_beat  (req),
        .out_vld  (f_vld),
        .out_data (f_data)
    );

    always_comb
    begin
        xr  = {f_data.mag_r, F'(0)};
        xi  = {f_data.mag_i, F'(0)};
        r0r = RW'(xr[XW-1:QB]);
        r0i = RW'(xi[XW-1:QB]);

        lr_entry.rem = r0r;
        lr_entry.xb  = xr[QB-1:0];
        lr_entry.quo = '0;
        lr_entry.ovf = r0r >= {1'b0, f_data.den};
        lr_entry.den = f_data.den;

        li_entry.rem = r0i;
        li_entry.xb  = xi[QB-1:0];
        li_entry.quo = '0;
        li_entry.ovf = r0i >= {1'b0, f_data.den};
        li_entry.den = f_data.den;

        side_next.cmd      = f_data.cmd;
        side_next.neg_r    = f_data.neg_r;
        side_next.neg_i    = f_data.neg_i;
        side_next.mag_r    = f_data.mag_r;
        side_next.mag_i    = f_data.mag_i;
        side_next.den_zero = f_data.den == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-1:0], f_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lr_reg      <= lr_entry;
            li_reg      <= li_entry;
            side_reg[0] <= side_next;
            for (int k = 1; k <= QB; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign lr_chain[0] = lr_reg;
    assign li_chain[0] = li_reg;

    for (genvar g = 0; g < QB; g++)
    begin : g_cell
        cau_div_cell u_cell_r (
            .clk      (clk),
            .en       (en),
            .lane_in  (lr_chain[g]),
            .lane_out (lr_chain[g+1])
        );
        cau_div_cell u_cell_i (
            .clk      (clk),
            .en       (en),
            .lane_in  (li_chain[g]),
            .lane_out (li_chain[g+1])
        );
    end

    always_comb
    begin
        sl = side_reg[QB];
        if (sl.cmd == CMD_DIV)
        begin
            mr  = MW'(lr_chain[QB].quo);
            mi  = MW'(li_chain[QB].quo);
            ovr = lr_chain[QB].ovf;
            ovi = li_chain[QB].ovf;
        end
        else
        begin
            mr  = sl.mag_r;
            mi  = sl.mag_i;
            ovr = 1'b0;
            ovi = 1'b0;
        end
        er = encode(sl.neg_r, mr, ovr);
        ei = encode(sl.neg_i, mi, ovi);
        if (sl.cmd == CMD_DIV && sl.den_zero)
        begin
            rsp_next.res_real = '0;
            rsp_next.res_imag = '0;
            rsp_next.status   = ST_DIV_ZERO;
        end
        else
        begin
            rsp_next.res_real = er.word;
            rsp_next.res_imag = ei.word;
            rsp_next.status   = (er.sat || ei.sat) ? ST_OVERFLOW : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
